// ===== hw/rtl/crpm_pkg.sv =====
// package: constants, codes and shared types of the capture ring period meter
package crpm_pkg;

    localparam int RING_DEPTH = 8;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CAP_W      = 16;
    localparam int OVF_W      = 6;
    localparam int EXT_W      = CAP_W + OVF_W;
    localparam int EDGE_W     = 3;

    localparam logic [PTR_W:0]   DEPTH_V  = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef struct packed {
        logic [PTR_W-1:0] write_pointer;
        logic [PTR_W-1:0] index_at_last_tick;
        logic [OVF_W-1:0] overflow_count;
        logic [EXT_W-1:0] last_extended_capture;
        logic [CAP_W-1:0] newest_capture;
        logic [CAP_W-1:0] older_capture;
    } crpm_state_t;

    typedef struct packed {
        logic              has_result;
        logic [EXT_W-1:0]  period;
        logic [EDGE_W-1:0] edge_count;
        logic              late_capture;
        logic              period_valid;
    } crpm_result_t;

endpackage

// ===== hw/rtl/crpm_step_logic.sv =====
// combinational update of meter state and tick result for one registered event
module crpm_step_logic (
    input  crpm_pkg::op_t                op,
    input  logic [crpm_pkg::CAP_W-1:0]   capture_value,
    input  logic                         counter_in_upper_half,
    input  crpm_pkg::crpm_state_t        state,
    output crpm_pkg::crpm_state_t        state_next,
    output crpm_pkg::crpm_result_t       result
);

    logic [crpm_pkg::PTR_W-1:0] edges;
    logic [31:0]                edges_wide;
    logic                       any_edge;
    logic                       low_half;
    logic                       late;
    logic [crpm_pkg::OVF_W-1:0] hi;
    logic [crpm_pkg::EXT_W-1:0] cap_new;
    logic [crpm_pkg::EXT_W-1:0] cap_ref;
    logic [crpm_pkg::EXT_W-1:0] diff;

    always_comb
    begin
        if (state.write_pointer >= state.index_at_last_tick)
        begin
            edges = state.write_pointer - state.index_at_last_tick;
        end
        else
        begin
            edges = crpm_pkg::PTR_W'({1'b0, state.write_pointer} + crpm_pkg::DEPTH_V
                                     - {1'b0, state.index_at_last_tick});
        end
        edges_wide = 32'(edges);
        any_edge   = (edges != '0);
        low_half   = !counter_in_upper_half;
        late       = any_edge && low_half && (state.newest_capture < state.older_capture);
        hi         = late ? state.overflow_count + crpm_pkg::OVF_W'(1) : state.overflow_count;
        cap_new    = {hi, state.newest_capture};
        if (edges == crpm_pkg::PTR_W'(1))
        begin
            cap_ref = state.last_extended_capture;
        end
        else
        begin
            cap_ref = {state.overflow_count, state.older_capture};
        end
        diff = cap_new - cap_ref;

        state_next = state;
        result     = '0;
        case (op)
            crpm_pkg::OP_CAPTURE:
            begin
                state_next.older_capture  = state.newest_capture;
                state_next.newest_capture = capture_value;
                state_next.write_pointer  = (state.write_pointer == crpm_pkg::PTR_LAST)
                                            ? '0
                                            : state.write_pointer + crpm_pkg::PTR_W'(1);
            end
            crpm_pkg::OP_TICK:
            begin
                state_next.index_at_last_tick = state.write_pointer;
                if (any_edge)
                begin
                    state_next.last_extended_capture = cap_new;
                end
                if (low_half)
                begin
                    state_next.overflow_count = state.overflow_count + crpm_pkg::OVF_W'(1);
                end
                result.has_result   = 1'b1;
                result.period       = any_edge ? diff : '0;
                result.edge_count   = edges_wide[crpm_pkg::EDGE_W-1:0];
                result.late_capture = late;
                result.period_valid = any_edge;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ===== hw/rtl/capture_ring_period_meter.sv =====
// top level of the capture ring period meter
//
// item channel (item_valid/item_ready) carries events: op = capture stores
// capture_value as the newest ring capture, op = tick asks for a measurement
// and reports whether the free counter is in its upper half.
// result channel (result_valid/result_ready) carries one result per tick:
// period modulo 2^22, edges since the previous tick, late-capture flag and
// period_valid. captures give no result.
// an event is registered in the input register at its transfer and processed
// from there; a tick's result is then registered in the result register.
// throughput: one event per cycle while no held result stalls a tick, set by the
// single input register feeding the update logic and the result register.
// at reset the pointers, overflow count and remembered capture clear, and the
// ring reads as all zero. while the receiver stalls, a held result holds the
// next tick in the input register and events behind it wait; captures ahead
// of that tick keep being taken.
module capture_ring_period_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               op,
    input  logic [crpm_pkg::CAP_W-1:0]         capture_value,
    input  logic                               counter_in_upper_half,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [crpm_pkg::EXT_W-1:0]         period,
    output logic [crpm_pkg::EDGE_W-1:0]        edge_count,
    output logic                               late_capture,
    output logic                               period_valid
);

    logic                        in_valid_reg;
    crpm_pkg::op_t               in_op_reg;
    logic [crpm_pkg::CAP_W-1:0]  in_value_reg;
    logic                        in_upper_reg;
    crpm_pkg::crpm_state_t       state_reg;
    crpm_pkg::crpm_state_t       state_next;
    crpm_pkg::crpm_result_t      step_result;
    crpm_pkg::crpm_result_t      result_reg;
    logic                        out_valid_reg;
    logic                        stage_advance;
    logic                        item_transfer;

    assign stage_advance = in_valid_reg
                           && ((in_op_reg == crpm_pkg::OP_CAPTURE) || !out_valid_reg
                               || result_ready);
    assign item_ready    = !in_valid_reg || stage_advance;
    assign item_transfer = item_valid && item_ready;

    crpm_step_logic u_step (
        .op                    (in_op_reg),
        .capture_value         (in_value_reg),
        .counter_in_upper_half (in_upper_reg),
        .state                 (state_reg),
        .state_next            (state_next),
        .result                (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (stage_advance)
            begin
                state_reg <= state_next;
            end
            if (stage_advance && step_result.has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_transfer)
        begin
            in_op_reg    <= crpm_pkg::op_t'(op);
            in_value_reg <= capture_value;
            in_upper_reg <= counter_in_upper_half;
        end
        if (stage_advance && step_result.has_result)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign period       = result_reg.period;
    assign edge_count   = result_reg.edge_count;
    assign late_capture = result_reg.late_capture;
    assign period_valid = result_reg.period_valid;

    a_no_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.period_valid)
        |-> (result_reg.period == '0 && !result_reg.late_capture))
        else $error("result without edges carries nonzero period or late flag");

    a_capture_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_advance && in_op_reg == crpm_pkg::OP_CAPTURE)
        |=> (state_reg.write_pointer != $past(state_reg.write_pointer)))
        else $error("capture did not advance write pointer");

    a_low_tick_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_advance && in_op_reg == crpm_pkg::OP_TICK && !in_upper_reg)
        |=> (state_reg.overflow_count
             == $past(state_reg.overflow_count) + crpm_pkg::OVF_W'(1)))
        else $error("low-half tick did not advance overflow count");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_advance && in_op_reg == crpm_pkg::OP_TICK) |=> out_valid_reg)
        else $error("tick produced no result");

endmodule
